@@ rtl/core/apts_pkg.sv @@
// Shared codes, constants, types and helpers of the aging priority scheduler.
package apts_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int DEF_ID_BITS   = 8;

  // Action codes
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_ADD    = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_SET    = 3'd3;
  localparam logic [2:0] ACT_PICK   = 3'd4;
  localparam logic [2:0] ACT_READ   = 3'd5;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  localparam logic signed [5:0] PRIO_MAX = 6'sd20;
  localparam logic signed [5:0] PRIO_MIN = -6'sd20;
  localparam logic signed [7:0] DYN_MIN  = -8'sd128;
  localparam logic [7:0]        QUANTUM_RESET = 8'd20;

  // Per-cell control for one cycle
  typedef struct packed {
    logic wr;       // load id and priority from the write bus
    logic shift;    // take the right neighbor's contents
    logic restore;  // dynamic priority back to static
    logic age;      // dynamic priority down by one, saturating
  } cell_ctrl_t;

  function automatic logic signed [5:0] clamp_prio(input logic signed [5:0] p);
    logic signed [5:0] r;
    r = p;
    if (p < PRIO_MIN) r = PRIO_MIN;
    if (p > PRIO_MAX) r = PRIO_MAX;
    return r;
  endfunction

endpackage

@@ rtl/core/aging_priority_task_scheduler_core.sv @@
// Top level of the aging priority task scheduler: sequencer over a row of slots.
//
// An action is taken when start is high and busy is low; its result shows on
// the out_ ports for one cycle with out_valid, and must be taken then. Tick,
// add, unknown actions and a pick on an empty list answer in the cycle after
// acceptance. Pick, remove, set priority and read priority scan the list one
// slot per cycle, comparing only the current slot: pick visits every entry,
// the others stop at the first slot holding the id and visit every entry when
// it is not found. busy is high during the scan.
// quantum_ticks is written over the cfg_ port, which is always ready.
module aging_priority_task_scheduler_core
  import apts_pkg::*;
#(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int ID_BITS   = DEF_ID_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_action,
  input  logic [7:0]        in_task_id,
  input  logic signed [5:0] in_prio,
  output logic              out_valid,
  output logic [7:0]        out_chosen_id,
  output logic              out_chosen_valid,
  output logic              out_preempt,
  output logic signed [5:0] out_prio_out,
  output logic [1:0]        out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TASKS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                state_r, state_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic signed [5:0]   prio_r, prio_nxt;
  logic [IW-1:0]       best_idx_r, best_idx_nxt;
  logic signed [7:0]   best_dp_r, best_dp_nxt;
  logic [ID_BITS-1:0]  best_id_r, best_id_nxt;
  logic [ID_BITS-1:0]  run_id_r, run_id_nxt;
  logic                run_valid_r, run_valid_nxt;
  logic signed [8:0]   quantum_left_r, quantum_left_nxt;
  logic [7:0]          quantum_ticks_r;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_chosen_id_r, out_chosen_id_nxt;
  logic                out_chosen_valid_r, out_chosen_valid_nxt;
  logic                out_preempt_r, out_preempt_nxt;
  logic signed [5:0]   out_prio_out_r, out_prio_out_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  logic [ID_BITS-1:0]  c_id [MAX_TASKS];
  logic signed [5:0]   c_sp [MAX_TASKS];
  logic signed [7:0]   c_dp [MAX_TASKS];
  cell_ctrl_t          c_ctrl [MAX_TASKS];

  logic                age_all;
  logic                wr_en, shift_en, restore_en;
  logic [IW-1:0]       wr_idx, shift_from, restore_idx;
  logic [ID_BITS-1:0]  wr_id;
  logic signed [5:0]   wr_prio;

  logic [ID_BITS-1:0]  id_in;
  logic signed [5:0]   prio_in;
  logic [IW-1:0]       cur;
  logic                at_end;
  logic signed [8:0]   q_dec;

  assign id_in   = ID_BITS'(in_task_id);
  assign prio_in = clamp_prio(in_prio);
  assign cur     = scan_r[IW-1:0];
  assign at_end  = (scan_r == count_r);
  assign q_dec   = (quantum_left_r > -9'sd1) ? quantum_left_r - 9'sd1 : quantum_left_r;

  // Sequence actions and compute next state
  always_comb begin
    state_nxt            = state_r;
    scan_nxt             = scan_r;
    count_nxt            = count_r;
    op_nxt               = op_r;
    id_nxt               = id_r;
    prio_nxt             = prio_r;
    best_idx_nxt         = best_idx_r;
    best_dp_nxt          = best_dp_r;
    best_id_nxt          = best_id_r;
    run_id_nxt           = run_id_r;
    run_valid_nxt        = run_valid_r;
    quantum_left_nxt     = quantum_left_r;
    out_valid_nxt        = 1'b0;
    out_chosen_id_nxt    = 8'd0;
    out_chosen_valid_nxt = 1'b0;
    out_preempt_nxt      = 1'b0;
    out_prio_out_nxt     = 6'sd0;
    out_status_nxt       = STAT_OK;
    age_all              = 1'b0;
    wr_en                = 1'b0;
    wr_idx               = count_r[IW-1:0];
    wr_id                = id_in;
    wr_prio              = prio_in;
    shift_en             = 1'b0;
    shift_from           = cur;
    restore_en           = 1'b0;
    restore_idx          = best_idx_r;

    if (state_r == S_IDLE) begin
      if (start) begin
        op_nxt   = in_action;
        id_nxt   = id_in;
        prio_nxt = prio_in;
        scan_nxt = '0;
        case (in_action)
          ACT_TICK: begin
            out_valid_nxt = 1'b1;
            if (run_valid_r) begin
              quantum_left_nxt = q_dec;
              out_preempt_nxt  = q_dec[8];
            end
          end
          ACT_ADD: begin
            out_valid_nxt = 1'b1;
            if (count_r == FULL_COUNT) begin
              out_status_nxt = STAT_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          ACT_PICK: begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_EMPTY;
            end else begin
              age_all   = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          ACT_REMOVE, ACT_SET, ACT_READ: begin
            state_nxt = S_SCAN;
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end
    end else if (op_r == ACT_PICK) begin
      // Track the lowest aged priority; ties keep the earlier slot
      if (at_end) begin
        restore_en           = 1'b1;
        run_id_nxt           = best_id_r;
        run_valid_nxt        = 1'b1;
        quantum_left_nxt     = 9'(quantum_ticks_r);
        out_valid_nxt        = 1'b1;
        out_chosen_id_nxt    = 8'(best_id_r);
        out_chosen_valid_nxt = 1'b1;
        state_nxt            = S_IDLE;
      end else begin
        if (scan_r == '0 || c_dp[cur] < best_dp_r) begin
          best_idx_nxt = cur;
          best_dp_nxt  = c_dp[cur];
          best_id_nxt  = c_id[cur];
        end
        scan_nxt = scan_r + 1'b1;
      end
    end else begin
      // Search for the earliest slot holding the id
      if (at_end) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_NOT_FOUND;
        state_nxt      = S_IDLE;
      end else if (c_id[cur] == id_r) begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (op_r)
          ACT_REMOVE: begin
            shift_en  = 1'b1;
            count_nxt = count_r - 1'b1;
            if (run_valid_r && run_id_r == id_r) run_valid_nxt = 1'b0;
          end
          ACT_SET: begin
            wr_en   = 1'b1;
            wr_idx  = cur;
            wr_id   = id_r;
            wr_prio = prio_r;
          end
          default: begin
            out_prio_out_nxt = c_sp[cur];
          end
        endcase
      end else begin
        scan_nxt = scan_r + 1'b1;
      end
    end
  end

  // Drive the slot row
  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
      logic [ID_BITS-1:0] nb_id;
      logic signed [5:0]  nb_sp;
      logic signed [7:0]  nb_dp;

      if (gi < MAX_TASKS - 1) begin : g_nb
        assign nb_id = c_id[gi+1];
        assign nb_sp = c_sp[gi+1];
        assign nb_dp = c_dp[gi+1];
      end else begin : g_last
        assign nb_id = c_id[gi];
        assign nb_sp = c_sp[gi];
        assign nb_dp = c_dp[gi];
      end

      assign c_ctrl[gi].wr      = wr_en && (wr_idx == IW'(gi));
      assign c_ctrl[gi].shift   = shift_en && (CW'(gi) >= CW'(shift_from))
                                  && (CW'(gi) + 1'b1 < count_r);
      assign c_ctrl[gi].restore = restore_en && (restore_idx == IW'(gi));
      assign c_ctrl[gi].age     = age_all && (CW'(gi) < count_r);

      apts_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk     (clk),
        .ctrl    (c_ctrl[gi]),
        .wr_id   (wr_id),
        .wr_prio (wr_prio),
        .nb_id   (nb_id),
        .nb_sp   (nb_sp),
        .nb_dp   (nb_dp),
        .id      (c_id[gi]),
        .sp      (c_sp[gi]),
        .dp      (c_dp[gi])
      );
    end
  endgenerate

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      scan_r          <= '0;
      count_r         <= '0;
      run_id_r        <= '0;
      run_valid_r     <= 1'b0;
      quantum_left_r  <= '0;
      quantum_ticks_r <= QUANTUM_RESET;
      out_valid_r     <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      scan_r         <= scan_nxt;
      count_r        <= count_nxt;
      run_id_r       <= run_id_nxt;
      run_valid_r    <= run_valid_nxt;
      quantum_left_r <= quantum_left_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid) quantum_ticks_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r               <= op_nxt;
    id_r               <= id_nxt;
    prio_r             <= prio_nxt;
    best_idx_r         <= best_idx_nxt;
    best_dp_r          <= best_dp_nxt;
    best_id_r          <= best_id_nxt;
    out_chosen_id_r    <= out_chosen_id_nxt;
    out_chosen_valid_r <= out_chosen_valid_nxt;
    out_preempt_r      <= out_preempt_nxt;
    out_prio_out_r     <= out_prio_out_nxt;
    out_status_r       <= out_status_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_chosen_id    = out_chosen_id_r;
  assign out_chosen_valid = out_chosen_valid_r;
  assign out_preempt      = out_preempt_r;
  assign out_prio_out     = out_prio_out_r;
  assign out_status       = out_status_r;

endmodule

@@ rtl/core/apts_cell.sv @@
// One ready-list slot: id, static and dynamic priority, with neighbor shift.
module apts_cell
  import apts_pkg::*;
#(
  parameter int ID_BITS = DEF_ID_BITS
) (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic [ID_BITS-1:0]  wr_id,
  input  logic signed [5:0]   wr_prio,
  input  logic [ID_BITS-1:0]  nb_id,
  input  logic signed [5:0]   nb_sp,
  input  logic signed [7:0]   nb_dp,
  output logic [ID_BITS-1:0]  id,
  output logic signed [5:0]   sp,
  output logic signed [7:0]   dp
);

  logic [ID_BITS-1:0] id_r, id_nxt;
  logic signed [5:0]  sp_r, sp_nxt;
  logic signed [7:0]  dp_r, dp_nxt;

  // Select the slot's next contents
  always_comb begin
    id_nxt = id_r;
    sp_nxt = sp_r;
    dp_nxt = dp_r;
    if (ctrl.wr) begin
      id_nxt = wr_id;
      sp_nxt = wr_prio;
      dp_nxt = 8'(wr_prio);
    end else if (ctrl.shift) begin
      id_nxt = nb_id;
      sp_nxt = nb_sp;
      dp_nxt = nb_dp;
    end else if (ctrl.restore) begin
      dp_nxt = 8'(sp_r);
    end else if (ctrl.age) begin
      if (dp_r != DYN_MIN) dp_nxt = dp_r - 8'sd1;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    sp_r <= sp_nxt;
    dp_r <= dp_nxt;
  end

  assign id = id_r;
  assign sp = sp_r;
  assign dp = dp_r;

endmodule

@@ rtl/core/apts_checker.sv @@
// Port-level checks of the scheduler core and their attachment.
module apts_checker
  import apts_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input logic              out_chosen_valid,
  input logic              out_preempt,
  input logic signed [5:0] out_prio_out,
  input logic [1:0]        out_status
);

  // A transfer ends the action, so the core is free in that cycle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // A chosen task always comes with good status and no preemption
  a_chosen_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_chosen_valid) |-> (out_status == STAT_OK && !out_preempt))
    else $error("chosen with bad status");

  // Preemption comes only from a tick, with good status and no returned priority
  a_preempt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_preempt) |-> (out_status == STAT_OK && out_prio_out == 6'sd0))
    else $error("preempt with other fields");

  // A returned priority is in range and only with good status
  a_prio_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_prio_out != 6'sd0) |->
      (out_status == STAT_OK && out_prio_out <= PRIO_MAX && out_prio_out >= PRIO_MIN))
    else $error("bad priority read");

endmodule

bind aging_priority_task_scheduler_core apts_checker u_apts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_chosen_valid (out_chosen_valid),
  .out_preempt      (out_preempt),
  .out_prio_out     (out_prio_out),
  .out_status       (out_status)
);
